>>> sv/ssir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set package
// Shared types, codes and defaults for the sorted set insert/remove block.
// ----------------------------------------------------------------------------
package ssir_pkg;

  // Default number of cells in the chain
  localparam int unsigned SsirCapacity = 16;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef logic signed [ValueW-1:0] ssir_value_t;
  typedef logic [StatusW-1:0]       ssir_status_t;
  typedef logic [CountW-1:0]        ssir_count_t;

  // Request command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } ssir_cmd_e;

  // Response status codes
  localparam ssir_status_t STAT_DONE = 2'd0;
  localparam ssir_status_t STAT_MISS = 2'd1;
  localparam ssir_status_t STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } ssir_state_e;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic compare;     // latch match / stop flags against the key
    logic update;      // apply the shift for the current command
    logic remove;      // command is a remove
    logic descending;  // current sort order
  } ssir_cell_ctrl_t;

endpackage

>>> sv/ssir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssir_req_if;
  import ssir_pkg::*;

  logic        valid;
  logic        ready;
  ssir_cmd_e   cmd;
  ssir_value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ssir_rsp_if;
  import ssir_pkg::*;

  logic         valid;
  logic         ready;
  ssir_status_t status;
  ssir_count_t  entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

>>> sv/sorted_set_insert_remove_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set insert/remove top level
// Keeps a duplicate-free sorted set of signed 32-bit values in a cell chain.
// ----------------------------------------------------------------------------
// Each request passes through an accept step, a compare step in which every
// cell compares its slot against the value, and an update step in which the
// cells shift one place along the chain on success and the response register
// is loaded. The update step waits while the previous response has not been
// taken, and no new request is taken until it is done. Slots carry no reset
// and need no clearing pass: only slots below the entry count are ever read.
// Changing the order with values held does not reorder them.
module sorted_set_insert_remove_top #(
  parameter int unsigned CAPACITY = ssir_pkg::SsirCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ssir_req_if.sink   req_i,
  ssir_rsp_if.source rsp_o
);
  import ssir_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  ssir_state_e     state_q, state_d;
  logic            desc_q;
  logic [CntW-1:0] count_q, count_d;
  ssir_cmd_e       cmd_q;
  ssir_value_t     key_q;
  logic            rsp_valid_q, rsp_valid_d;
  ssir_status_t    status_q, status_d;
  ssir_cell_ctrl_t cell_ctrl;
  logic            found;
  logic            full;
  logic            load_rsp;

  ssir_value_t       val_w [CAPACITY];
  logic [CAPACITY:0] ge_w;
  logic [CAPACITY:0] gone_w;
  logic [CAPACITY-1:0] occ_w;

  // Order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.value;
    end
  end

  // Cell chain
  assign ge_w[0]   = 1'b0;
  assign gone_w[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssir_value_t left_val;
    ssir_value_t right_val;

    assign occ_w[i] = CntW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = val_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = val_w[i+1];
    end

    ssir_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .key_i      (key_q),
      .occ_i      (occ_w[i]),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .ge_i       (ge_w[i]),
      .gone_i     (gone_w[i]),
      .ge_o       (ge_w[i+1]),
      .gone_o     (gone_w[i+1]),
      .val_o      (val_w[i])
    );
  end

  assign found = gone_w[CAPACITY];
  assign full  = (count_q == CntW'(CAPACITY));

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      status_q <= status_d;
    end
  end

  // Next state, cell control and response
  always_comb begin
    state_d              = state_q;
    count_d              = count_q;
    status_d             = STAT_DONE;
    load_rsp             = 1'b0;
    rsp_valid_d          = rsp_valid_q & ~rsp_o.ready;
    cell_ctrl.compare    = 1'b0;
    cell_ctrl.update     = 1'b0;
    cell_ctrl.remove     = (cmd_q == CMD_REMOVE);
    cell_ctrl.descending = desc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cell_ctrl.compare = 1'b1;
        state_d           = ST_UPD;
      end
      ST_UPD: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (cmd_q == CMD_REMOVE) begin
            if (found) begin
              cell_ctrl.update = 1'b1;
              count_d          = count_q - CntW'(1);
            end else begin
              status_d = STAT_MISS;
            end
          end else begin
            priority if (found) begin
              status_d = STAT_MISS;
            end else if (full) begin
              status_d = STAT_FULL;
            end else begin
              cell_ctrl.update = 1'b1;
              count_d          = count_q + CntW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = CountW'(count_q);

  // Count stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted insert always finds a place in the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.update && !cell_ctrl.remove) |-> ge_w[CAPACITY])
    else $error("insert found no place in the chain");

  // A remove that matched only happens with entries held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.update && cell_ctrl.remove) |-> (count_q != '0))
    else $error("remove matched in an empty set");

  // Every shift produces a response on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.update |=> (rsp_valid_q && status_q == STAT_DONE))
    else $error("shift without a done response");

endmodule

>>> sv/ssir_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one slot, compares it against the broadcast key and shifts its value
// to or from a neighbor under the flags rippled along the chain.
// ----------------------------------------------------------------------------
module ssir_cell (
  input  logic                      clk_i,
  input  ssir_pkg::ssir_cell_ctrl_t ctrl_i,
  input  ssir_pkg::ssir_value_t     key_i,
  input  logic                      occ_i,
  input  ssir_pkg::ssir_value_t     left_val_i,
  input  ssir_pkg::ssir_value_t     right_val_i,
  input  logic                      ge_i,
  input  logic                      gone_i,
  output logic                      ge_o,
  output logic                      gone_o,
  output ssir_pkg::ssir_value_t     val_o
);
  import ssir_pkg::*;

  ssir_value_t val_q;
  logic        match_q;
  logic        stop_q;
  logic        precedes;

  // Held value comes before the key in the current order
  assign precedes = ctrl_i.descending ? (val_q > key_i) : (val_q < key_i);

  // Latch per-slot flags; a free slot always stops the insert search
  always_ff @(posedge clk_i) begin
    if (ctrl_i.compare) begin
      match_q <= occ_i & (val_q == key_i);
      stop_q  <= ~occ_i | ~precedes;
    end
  end

  // Ripple: insert point reached, matching slot passed
  assign ge_o   = ge_i | stop_q;
  assign gone_o = gone_i | match_q;

  // Shift right on insert, left on remove
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      if (ctrl_i.remove) begin
        if (gone_o) begin
          val_q <= right_val_i;
        end
      end else if (ge_i) begin
        val_q <= left_val_i;
      end else if (ge_o) begin
        val_q <= key_i;
      end
    end
  end

  assign val_o = val_q;

endmodule
